// ----- rtl/core/mfa_pkg.sv -----
// ----------------------------------------------------------------------------
// mfa_pkg
// shared widths, types and register codes of the mesh face area block
// ----------------------------------------------------------------------------
package mfa_pkg;

  localparam int COORD_W  = 24;
  localparam int N_VERT   = 4;
  localparam int N_AXIS   = 3;
  localparam int IN_W     = N_VERT * N_AXIS * COORD_W;
  localparam int N_LANES  = 4;

  // lane operand: 4*v - sum(v) needs three bits beyond a coordinate
  localparam int OP_W     = COORD_W + 3;
  localparam int PROD_W   = 2 * OP_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int HALF_W   = MAG_W / 2;
  localparam int PART_W   = 2 * HALF_W;
  localparam int RAD_W    = 2 * MAG_W;
  localparam int ROOT_W   = MAG_W;
  localparam int LANE_LAT = 6 + ROOT_W;
  localparam int CZ_DLY   = 4 + ROOT_W;
  localparam int SUM_W    = ROOT_W + 2;

  localparam int AREA_W     = 48;
  localparam int TRI_SHIFT  = 1;
  localparam int QUAD_SHIFT = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] IdxCorners = 1'd0;
  localparam logic [CFG_IDX_W-1:0] IdxDims    = 1'd1;
  localparam logic [2:0] CornersQuad  = 3'd4;
  localparam logic [2:0] CornersReset = 3'd3;
  localparam logic [1:0] DimsPlanar   = 2'd2;
  localparam logic [1:0] DimsReset    = 2'd3;

  typedef logic signed [OP_W-1:0] op_t;

  typedef struct packed {
    op_t x;
    op_t y;
    op_t z;
  } vec_t;

  typedef struct packed {
    logic valid;
    logic quad;
    logic planar;
  } ctl_t;

endpackage

// ----- rtl/core/mfa_setup.sv -----
// ----------------------------------------------------------------------------
// mfa_setup
// forms the edge, diagonal or centroid-relative vectors that each lane crosses
// ----------------------------------------------------------------------------
module mfa_setup (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [mfa_pkg::IN_W-1:0] verts_i,
  input  mfa_pkg::ctl_t        ctl_i,
  output mfa_pkg::vec_t        a_o [mfa_pkg::N_LANES],
  output mfa_pkg::vec_t        b_o [mfa_pkg::N_LANES]
);
  import mfa_pkg::*;

  logic signed [COORD_W-1:0] v   [N_VERT][N_AXIS];
  logic signed [OP_W-1:0]    sum [N_AXIS];
  logic signed [OP_W-1:0]    w   [N_VERT][N_AXIS];
  logic signed [OP_W-1:0]    e1  [N_AXIS];
  logic signed [OP_W-1:0]    e2  [N_AXIS];
  logic signed [OP_W-1:0]    p   [N_AXIS];
  logic signed [OP_W-1:0]    q   [N_AXIS];
  vec_t a_d [N_LANES];
  vec_t b_d [N_LANES];
  logic [1:0] ia, ib;

  always_comb begin
    for (int k = 0; k < N_VERT; k++) begin
      for (int j = 0; j < N_AXIS; j++) begin
        v[k][j] = verts_i[(k*N_AXIS + j)*COORD_W +: COORD_W];
      end
    end
    for (int j = 0; j < N_AXIS; j++) begin
      sum[j] = OP_W'(v[0][j]) + OP_W'(v[1][j]) + OP_W'(v[2][j]) + OP_W'(v[3][j]);
      for (int k = 0; k < N_VERT; k++) begin
        w[k][j] = (OP_W'(v[k][j]) <<< 2) - sum[j];
      end
      e1[j] = OP_W'(v[1][j]) - OP_W'(v[0][j]);
      e2[j] = OP_W'(v[2][j]) - OP_W'(v[0][j]);
      p[j]  = ctl_i.quad ? OP_W'(v[2][j]) - OP_W'(v[0][j]) : e1[j];
      q[j]  = ctl_i.quad ? OP_W'(v[3][j]) - OP_W'(v[1][j]) : e2[j];
    end
    // fan about the centroid: lane k crosses w[k+2] with w[k+1]
    for (int k = 0; k < N_LANES; k++) begin
      ia = 2'(k + 2);
      ib = 2'(k + 1);
      a_d[k] = '{x: w[ia][0], y: w[ia][1], z: w[ia][2]};
      b_d[k] = '{x: w[ib][0], y: w[ib][1], z: w[ib][2]};
    end
    if (ctl_i.planar) begin
      a_d[0] = '{x: p[0], y: p[1], z: '0};
      b_d[0] = '{x: q[0], y: q[1], z: '0};
    end else if (!ctl_i.quad) begin
      a_d[0] = '{x: e1[0], y: e1[1], z: e1[2]};
      b_d[0] = '{x: e2[0], y: e2[1], z: e2[2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= a_d;
      b_o <= b_d;
    end
  end

endmodule

// ----- rtl/core/mfa_lane.sv -----
// ----------------------------------------------------------------------------
// mfa_lane
// cross product, squared norm and pipelined integer square root
// ----------------------------------------------------------------------------
module mfa_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  mfa_pkg::vec_t                     a_i,
  input  mfa_pkg::vec_t                     b_i,
  output logic [mfa_pkg::ROOT_W-1:0]        root_o,
  output logic signed [mfa_pkg::CROSS_W-1:0] cz_o
);
  import mfa_pkg::*;

  logic signed [PROD_W-1:0]  prod_q [6];
  logic signed [CROSS_W-1:0] c_q    [N_AXIS];
  logic [MAG_W-1:0]          mag_q  [N_AXIS];
  logic [PART_W-1:0]         hh_q   [N_AXIS];
  logic [PART_W-1:0]         hl_q   [N_AXIS];
  logic [PART_W-1:0]         ll_q   [N_AXIS];
  logic [RAD_W-1:0]          sq_q   [N_AXIS];
  logic [RAD_W-1:0]          rad_q;
  logic [RAD_W-1:0]          rm_q   [1:ROOT_W];
  logic [ROOT_W-1:0]         rt_q   [1:ROOT_W];
  logic signed [CROSS_W-1:0] czd_q  [CZ_DLY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= $signed(a_i.y) * $signed(b_i.z);
      prod_q[1] <= $signed(a_i.z) * $signed(b_i.y);
      prod_q[2] <= $signed(a_i.z) * $signed(b_i.x);
      prod_q[3] <= $signed(a_i.x) * $signed(b_i.z);
      prod_q[4] <= $signed(a_i.x) * $signed(b_i.y);
      prod_q[5] <= $signed(a_i.y) * $signed(b_i.x);
      for (int j = 0; j < N_AXIS; j++) begin
        c_q[j] <= CROSS_W'(prod_q[2*j]) - CROSS_W'(prod_q[2*j+1]);
        mag_q[j] <= c_q[j][CROSS_W-1] ? MAG_W'(-c_q[j]) : MAG_W'(c_q[j]);
        // square split into half-width partial products
        hh_q[j] <= mag_q[j][MAG_W-1:HALF_W] * mag_q[j][MAG_W-1:HALF_W];
        hl_q[j] <= mag_q[j][MAG_W-1:HALF_W] * mag_q[j][HALF_W-1:0];
        ll_q[j] <= mag_q[j][HALF_W-1:0] * mag_q[j][HALF_W-1:0];
        sq_q[j] <= (RAD_W'(hh_q[j]) << (2*HALF_W)) + (RAD_W'(hl_q[j]) << (HALF_W+1))
                   + RAD_W'(ll_q[j]);
      end
      rad_q <= sq_q[0] + sq_q[1] + sq_q[2];
      czd_q[0] <= c_q[2];
      for (int i = 1; i < CZ_DLY; i++) begin
        czd_q[i] <= czd_q[i-1];
      end
    end
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rm_in;
    logic [ROOT_W-1:0] rt_in;
    logic [RAD_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign rm_in = rad_q;
      assign rt_in = '0;
    end else begin : g_next
      assign rm_in = rm_q[k];
      assign rt_in = rt_q[k];
    end

    assign trial = (RAD_W'(rt_in) << (B + 1)) | (RAD_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rm_in >= trial) begin
          rm_q[k+1] <= rm_in - trial;
          rt_q[k+1] <= rt_in | (ROOT_W'(1) << B);
        end else begin
          rm_q[k+1] <= rm_in;
          rt_q[k+1] <= rt_in;
        end
      end
    end
  end

  assign root_o = rt_q[ROOT_W];
  assign cz_o   = czd_q[CZ_DLY-1];

endmodule

// ----- rtl/core/mfa_merge.sv -----
// ----------------------------------------------------------------------------
// mfa_merge
// combines lane results, rounds to Q24.24 and saturates
// ----------------------------------------------------------------------------
module mfa_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  mfa_pkg::ctl_t                      ctl_i,
  input  logic [mfa_pkg::ROOT_W-1:0]         root_i [mfa_pkg::N_LANES],
  input  logic signed [mfa_pkg::CROSS_W-1:0] cz_i,
  output logic                               valid_o,
  output logic [mfa_pkg::AREA_W-1:0]         area_o,
  output logic                               sat_o
);
  import mfa_pkg::*;

  logic             valid1_q;
  logic [SUM_W-1:0] mag_q;
  logic             neg_q;
  logic             quad_q;
  logic [SUM_W-1:0] mag_d;
  logic [SUM_W:0]   rnd;
  logic [SUM_W-1:0] res;
  logic [SUM_W-1:0] lim;
  logic             sat;
  logic [AREA_W-1:0] mag_out;

  always_comb begin
    if (ctl_i.planar) begin
      mag_d = cz_i[CROSS_W-1] ? SUM_W'(-cz_i) : SUM_W'(cz_i);
    end else if (ctl_i.quad) begin
      mag_d = SUM_W'(root_i[0]) + SUM_W'(root_i[1]) + SUM_W'(root_i[2]) + SUM_W'(root_i[3]);
    end else begin
      mag_d = SUM_W'(root_i[0]);
    end
  end

  always_comb begin
    if (quad_q) begin
      rnd = (SUM_W+1)'(mag_q) + (SUM_W+1)'(1 << (QUAD_SHIFT - 1));
      res = SUM_W'(rnd >> QUAD_SHIFT);
    end else begin
      rnd = (SUM_W+1)'(mag_q) + (SUM_W+1)'(1 << (TRI_SHIFT - 1));
      res = SUM_W'(rnd >> TRI_SHIFT);
    end
    // negative range reaches one step further
    lim = (SUM_W'(1) << (AREA_W - 1)) - (neg_q ? SUM_W'(0) : SUM_W'(1));
    sat = res > lim;
    mag_out = sat ? AREA_W'(lim) : AREA_W'(res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid_o  <= 1'b0;
    end else if (en_i) begin
      valid1_q <= ctl_i.valid;
      valid_o  <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg_q  <= ctl_i.planar & cz_i[CROSS_W-1];
      quad_q <= ctl_i.quad & ~ctl_i.planar;
      area_o <= neg_q ? -mag_out : mag_out;
      sat_o  <= sat;
    end
  end

endmodule

// ----- rtl/core/mesh_face_area.sv -----
// ----------------------------------------------------------------------------
// mesh_face_area
// area of a triangle or quad face, planar signed or spatial, in Q24.24
// ----------------------------------------------------------------------------
// One face enters per cycle while the result side does not stall; the depth is
// set by the square root, which resolves one bit per stage over 54 stages in
// each of four lanes. Each lane crosses two vectors and takes the norm: lane
// zero serves triangles and planar faces, all four serve a spatial quad fanned
// about its centroid, and a merge stage sums, rounds and saturates. A stall
// on the result side holds the whole pipeline, so s_axis_tready follows
// m_axis_tready while a result is waiting. Configuration writes take effect
// on faces accepted after them.
module mesh_face_area (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mfa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mfa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z v3_x v3_y v3_z
  input  logic [mfa_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // area
  output logic [mfa_pkg::AREA_W-1:0]       m_axis_tdata,
  // saturated
  output logic [0:0]                       m_axis_tuser
);
  import mfa_pkg::*;

  localparam int CTL_DEPTH = 2 + LANE_LAT;

  logic [2:0]      corners_q;
  logic [1:0]      dims_q;
  logic            adv;
  logic [IN_W-1:0] verts_q;
  ctl_t            ctl_q [CTL_DEPTH];
  ctl_t            ctl_in;
  vec_t            a_op [N_LANES];
  vec_t            b_op [N_LANES];
  logic [ROOT_W-1:0] root [N_LANES];
  logic signed [CROSS_W-1:0] cz;
  logic            sat;

  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corners_q <= CornersReset;
      dims_q    <= DimsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        IdxCorners: corners_q <= cfg_data_i;
        IdxDims:    dims_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign ctl_in = '{valid: s_axis_tvalid, quad: corners_q == CornersQuad,
                    planar: dims_q == DimsPlanar};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CTL_DEPTH; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (adv) begin
      ctl_q[0] <= ctl_in;
      for (int i = 1; i < CTL_DEPTH; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      verts_q <= s_axis_tdata;
    end
  end

  mfa_setup u_setup (
    .clk_i   (clk_i),
    .en_i    (adv),
    .verts_i (verts_q),
    .ctl_i   (ctl_q[0]),
    .a_o     (a_op),
    .b_o     (b_op)
  );

  mfa_lane u_lane0 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (a_op[0]),
    .b_i    (b_op[0]),
    .root_o (root[0]),
    .cz_o   (cz)
  );

  for (genvar l = 1; l < N_LANES; l++) begin : g_lane
    mfa_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .a_i    (a_op[l]),
      .b_i    (b_op[l]),
      .root_o (root[l]),
      .cz_o   ()
    );
  end

  mfa_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .ctl_i   (ctl_q[CTL_DEPTH-1]),
    .root_i  (root),
    .cz_i    (cz),
    .valid_o (m_axis_tvalid),
    .area_o  (m_axis_tdata),
    .sat_o   (sat)
  );

  assign m_axis_tuser = sat;

endmodule
